>>> src/vdpd_pkg.sv
package vdpd_pkg;

   // Width of the running position and of the delta being gathered.
   localparam int POSITION_BITS = 32;

   localparam int GROUP_BITS = 7;
   localparam int SHIFT_BITS = 6;

   localparam logic [7:0] GROUP_MASK = 8'h7F;
   localparam logic [7:0] CONT_BIT   = 8'h80;

   localparam logic [SHIFT_BITS-1:0] SHIFT_MAX  = 6'd63;
   localparam logic [SHIFT_BITS-1:0] GROUP_STEP = 6'd7;

   // Decoder state carried from one byte to the next.
   typedef struct packed {
      logic [POSITION_BITS-1:0] running;
      logic [POSITION_BITS-1:0] partial;
      logic [SHIFT_BITS-1:0]    shift;
   } vdpd_state_type;

   // One decoded position.
   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic                     last_of_list;
      logic                     cut_short;
   } vdpd_result_type;

endpackage

>>> src/vdpd_req_if.sv
interface vdpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       list_end;

   modport source (output valid, output data_byte, output list_end, input ready);
   modport sink   (input valid, input data_byte, input list_end, output ready);
endinterface

>>> src/vdpd_rsp_if.sv
interface vdpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] position;
   logic        last_of_list;
   logic        cut_short;

   modport source (output valid, output position, output last_of_list,
                   output cut_short, input ready);
   modport sink   (input valid, input position, input last_of_list,
                   input cut_short, output ready);
endinterface

>>> src/vdpd_step.sv
module vdpd_step (
   input  vdpd_pkg::vdpd_state_type  state,
   input  logic [7:0]                data_byte,
   input  logic                      list_end,
   output vdpd_pkg::vdpd_state_type  state_in,
   output logic                      emit,
   output vdpd_pkg::vdpd_result_type result
);

   localparam int EXT_BITS = vdpd_pkg::POSITION_BITS + vdpd_pkg::GROUP_BITS;

   logic                                more;
   logic [EXT_BITS-1:0]                 group_ext;
   logic [EXT_BITS-1:0]                 group_shifted;
   logic [vdpd_pkg::POSITION_BITS-1:0]  partial_new;
   logic [vdpd_pkg::POSITION_BITS-1:0]  sum;
   logic [vdpd_pkg::SHIFT_BITS-1:0]     shift_new;

   always_comb begin
      more          = (data_byte & vdpd_pkg::CONT_BIT) != 8'd0;
      group_ext     = EXT_BITS'(data_byte & vdpd_pkg::GROUP_MASK);
      group_shifted = group_ext << state.shift;

      // A group that starts at or beyond the position width adds nothing.
      if (32'(state.shift) < 32'(vdpd_pkg::POSITION_BITS)) begin
         partial_new = state.partial | group_shifted[vdpd_pkg::POSITION_BITS-1:0];
      end else begin
         partial_new = state.partial;
      end

      if (state.shift > vdpd_pkg::SHIFT_MAX - vdpd_pkg::GROUP_STEP) begin
         shift_new = vdpd_pkg::SHIFT_MAX;
      end else begin
         shift_new = state.shift + vdpd_pkg::GROUP_STEP;
      end

      sum  = state.running + partial_new;
      emit = !more || list_end;

      result.position     = sum;
      result.last_of_list = list_end;
      result.cut_short    = more && list_end;

      if (!emit) begin
         state_in.running = state.running;
         state_in.partial = partial_new;
         state_in.shift   = shift_new;
      end else begin
         state_in.running = list_end ? '0 : sum;
         state_in.partial = '0;
         state_in.shift   = '0;
      end
   end

endmodule

>>> src/varint_delta_position_decoder.sv
// Varint delta position decoder.
//
// The req channel brings the encoded bytes of position lists, one item per
// byte, with list_end set on the final byte of each list. Each byte adds its
// 7-bit group, low group first, to the delta being gathered. A byte whose top
// bit is clear closes the delta: it is added to the running position and the
// new position leaves on the rsp channel as one item. If a list ends while a
// varint is still open, the partial delta is added anyway and the item carries
// cut_short. last_of_list marks the final position of a list, after which the
// running position starts again from zero.
//
// A byte's position, if it produces one, appears on rsp in the next cycle. One
// byte per cycle is sustained while rsp takes its items; the figure rests on
// the combinational shift, OR and add from the state registers to the output
// register. While a result waits, req stays ready as long as rsp is taken in
// that same cycle; if rsp stalls with a result held, req drops ready.
// Synchronous reset clears the running position, the open delta and the
// output valid flag, but not the output payload. No clearing pass is needed.
module varint_delta_position_decoder (
   input  logic              clock,
   input  logic              reset,
   vdpd_req_if.sink          req,
   vdpd_rsp_if.source        rsp
);

   // Decoder state and its next value.
   vdpd_pkg::vdpd_state_type  state_ff;
   vdpd_pkg::vdpd_state_type  state_in;

   // Output register, which also parts the two handshakes.
   logic                      rsp_valid_ff;
   vdpd_pkg::vdpd_result_type result_ff;

   vdpd_pkg::vdpd_result_type result_in;
   logic                      emit;
   logic                      accept;

   vdpd_step u_step (
      .state     (state_ff),
      .data_byte (req.data_byte),
      .list_end  (req.list_end),
      .state_in  (state_in),
      .emit      (emit),
      .result    (result_in)
   );

   // The output register is free when empty or when its item leaves now.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // The payload needs no reset; it only loads with a new result.
      if (accept && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.position     = 32'(result_ff.position);
   assign rsp.last_of_list = result_ff.last_of_list;
   assign rsp.cut_short    = result_ff.cut_short;

   // The group shift only ever holds a multiple of seven or its saturated value.
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.shift <= 6'd56 || state_ff.shift == vdpd_pkg::SHIFT_MAX)
      else $error("group shift left its legal values");

   // A closing byte or a list end always yields a result in the next cycle.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept && (!req.data_byte[7] || req.list_end)) |=> rsp_valid_ff)
      else $error("closing byte produced no result");

   // The end of a list returns all running state to zero.
   a_list_clear: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept && req.list_end) |=> (state_ff == '0))
      else $error("state not cleared at end of list");

   // A continuation byte inside a list leaves the running position alone.
   a_cont_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept && req.data_byte[7] && !req.list_end)
      |=> $stable(state_ff.running))
      else $error("running position moved on a continuation byte");

   // A cut-short result is always the last of its list.
   a_cut_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.cut_short) |-> result_ff.last_of_list)
      else $error("cut-short result not marked last of list");

endmodule
